### hdl/oblique_tree_classify_core_defines.svh
// Assertion macros shared by the classifier RTL.
// Each macro expects clk and arst_n to exist in the scope where it is used.
`ifndef OBLIQUE_TREE_CLASSIFY_CORE_DEFINES_SVH
`define OBLIQUE_TREE_CLASSIFY_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define OTC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define OTC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/otc_pkg.sv
// Package of the oblique tree classifier: codes, states, field widths and defaults.
// No dependencies.
`timescale 1ns / 1ps

package otc_pkg;

	localparam int MAX_NODES_DEF     = 256;
	localparam int MAX_PROJ_ROWS_DEF = 1024;
	localparam int NUM_FEATURES_DEF  = 64;

	localparam int CUT_W   = 40;
	localparam int ACC_W   = 48;
	localparam int PROD_W  = 32;
	localparam int LABEL_W = 16;
	localparam int FEAT_W  = 7;

	typedef enum logic [1:0] {
		OP_LOAD_NODE = 2'd0,
		OP_LOAD_ROW  = 2'd1,
		OP_LOAD_FEAT = 2'd2,
		OP_EVAL      = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_NODE,
		ST_CHK,
		ST_CNT_RD,
		ST_CNT_AC,
		ST_SEG,
		ST_PR_RD,
		ST_PR_EV,
		ST_FT_EV,
		ST_ACC,
		ST_CMP,
		ST_FIN
	} state_t;

	// Control of the shared multiply-accumulate unit.
	typedef struct packed {
		logic clr;
		logic mul;
		logic acc;
	} mac_ctl_t;

endpackage

### hdl/otc_item_if.sv
// Channel interfaces of the classifier: input items and result items.
// Depends on nothing but the field widths written out here.
`timescale 1ns / 1ps

interface otc_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic [9:0]         index;
	logic [7:0]         child_link;
	logic [7:0]         split_group;
	logic signed [39:0] cut_value;
	logic [15:0]        leaf_label;
	logic [6:0]         proj_feature;
	logic [7:0]         proj_group;
	logic signed [15:0] proj_coef;
	logic signed [15:0] feature_value;

	modport source (output valid, operation, index, child_link, split_group, cut_value,
		leaf_label, proj_feature, proj_group, proj_coef, feature_value, input ready);
	modport sink (input valid, operation, index, child_link, split_group, cut_value,
		leaf_label, proj_feature, proj_group, proj_coef, feature_value, output ready);
endinterface

interface otc_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] class_label;
	logic        walk_error;

	modport source (output valid, class_label, walk_error, input ready);
	modport sink (input valid, class_label, walk_error, output ready);
endinterface

### hdl/otc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module otc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### hdl/otc_mac.sv
// Shared multiply-accumulate unit with the cut compare of the classifier.
// Depends on otc_pkg.
`timescale 1ns / 1ps

module otc_mac (
	input  logic                               clk,
	input  otc_pkg::mac_ctl_t                  ctl,
	input  logic signed [15:0]                 feat,
	input  logic signed [15:0]                 coef,
	input  logic signed [otc_pkg::CUT_W-1:0]   cut,
	output logic                               below
);
	import otc_pkg::*;

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  cut_ext;

	// Product register, then the exact accumulator.
	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prod_s1 <= feat * coef;
		end
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.acc) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end
	end

	// Signed compare of the sum against the node's cut.
	assign cut_ext = ACC_W'(cut);
	assign below   = acc_q < cut_ext;
endmodule

### hdl/oblique_tree_classify_core.sv
// Oblique decision tree classifier: top level with the walk sequencer and stores.
// Depends on otc_pkg, otc_item_if, otc_result_if, otc_ram, otc_mac and the defines header.
//
// Use: items arrive on item_ch (valid/ready). Load node, load projection row and
// load feature items write one store entry each if the index fits the store; they give no
// result. An evaluate item walks the tree from node 0 and gives one result item
// on result_ch: the leaf label, or label 0 with walk_error set.
// For each internal node visited, the walk counts leaves through the single node
// memory read port, scans the segment through the single row memory port and
// runs one multiply-accumulate on the shared multiplier for each row that matches.
// item_ch.ready is high only while the sequencer is idle; one item is at work
// at a time.
// A finished result waits in the output register; loads and a new evaluate are
// still taken meanwhile, and a second result holds in the sequencer until the
// receiver takes the first one.
// Reset clears the sequencer, the output valid and the loaded row count; the
// tree and feature stores are not cleared and must be loaded before use.
`timescale 1ns / 1ps
`include "oblique_tree_classify_core_defines.svh"

module oblique_tree_classify_core #(
	parameter int MAX_NODES     = otc_pkg::MAX_NODES_DEF,
	parameter int MAX_PROJ_ROWS = otc_pkg::MAX_PROJ_ROWS_DEF,
	parameter int NUM_FEATURES  = otc_pkg::NUM_FEATURES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	otc_item_if.sink     item_ch,
	otc_result_if.source result_ch
);
	import otc_pkg::*;

	localparam int NAW   = $clog2(MAX_NODES);
	localparam int SW    = $clog2(MAX_NODES + 1);
	localparam int RAW   = $clog2(MAX_PROJ_ROWS);
	localparam int RCW   = $clog2(MAX_PROJ_ROWS + 1);
	localparam int FAW   = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
	localparam int NODE_W = 8 + 8 + CUT_W + LABEL_W;
	localparam int ROW_W  = FEAT_W + 8 + 16;

	state_t state_q, state_nxt;

	// Walk registers.
	logic [NAW-1:0]          cur_q;
	logic [SW-1:0]           steps_q;
	logic [NAW-1:0]          k_q;
	logic [NAW:0]            leaves_q;
	logic [NAW:0]            seg_q;
	logic [RCW-1:0]          t_q;
	logic [RCW-1:0]          delims_q;
	logic [RCW-1:0]          row_cnt_q;
	logic [7:0]              child_q;
	logic [7:0]              grp_q;
	logic signed [CUT_W-1:0] cut_q;
	logic signed [15:0]      coef_q;
	logic [LABEL_W-1:0]      res_label_q;
	logic                    res_err_q;
	logic                    out_valid_q;
	logic [LABEL_W-1:0]      out_label_q;
	logic                    out_err_q;

	// Store ports.
	logic                    node_we, row_we, feat_we;
	logic [NAW-1:0]          node_raddr;
	logic [NODE_W-1:0]       node_rdata;
	logic [ROW_W-1:0]        row_rdata;
	logic [FAW-1:0]          feat_raddr;
	logic [15:0]             feat_rdata;

	logic                    accept;
	logic                    out_free;
	mac_ctl_t                mac_ctl;
	logic                    below;

	// Decoded read data.
	logic [7:0]              nd_child, nd_group;
	logic signed [CUT_W-1:0] nd_cut;
	logic [LABEL_W-1:0]      nd_label;
	logic [FEAT_W-1:0]       rw_feat;
	logic [7:0]              rw_group;
	logic signed [15:0]      rw_coef;

	// Walk conditions.
	logic                    step_over;
	logic                    cnt_last;
	logic [NAW+1:0]          seg_full;
	logic                    seg_neg;
	logic                    rows_done;
	logic                    seg_match;
	logic                    row_hit;
	logic                    feat_bad;
	logic [8:0]              next_node;
	logic                    next_bad;

	assign {nd_child, nd_group, nd_cut, nd_label} = node_rdata;
	assign {rw_feat, rw_group, rw_coef}           = row_rdata;

	assign accept    = item_ch.valid && item_ch.ready;
	assign out_free  = !out_valid_q || result_ch.ready;
	assign step_over = 32'(steps_q) >= MAX_NODES;
	assign cnt_last  = k_q == cur_q;
	assign seg_full  = $signed({2'b00, cur_q}) - $signed({1'b0, leaves_q});
	assign seg_neg   = seg_full[NAW+1];
	assign rows_done = t_q >= row_cnt_q;
	assign seg_match = 32'(delims_q) == 32'(seg_q);
	assign row_hit   = seg_match && (rw_group == grp_q);
	assign feat_bad  = 32'(rw_feat) > NUM_FEATURES;
	assign next_node = {1'b0, child_q} - 9'(below);
	assign next_bad  = 32'(next_node) >= MAX_NODES;

	// Stores.
	otc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (NAW'(item_ch.index)),
		.wdata ({item_ch.child_link, item_ch.split_group, item_ch.cut_value,
			item_ch.leaf_label}),
		.raddr (node_raddr),
		.rdata (node_rdata)
	);

	otc_ram #(.WIDTH(ROW_W), .DEPTH(MAX_PROJ_ROWS)) u_row_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (RAW'(item_ch.index)),
		.wdata ({item_ch.proj_feature, item_ch.proj_group, item_ch.proj_coef}),
		.raddr (RAW'(t_q)),
		.rdata (row_rdata)
	);

	otc_ram #(.WIDTH(16), .DEPTH(NUM_FEATURES)) u_feat_ram (
		.clk   (clk),
		.we    (feat_we),
		.waddr (FAW'(item_ch.index)),
		.wdata (item_ch.feature_value),
		.raddr (feat_raddr),
		.rdata (feat_rdata)
	);

	// Shared multiply-accumulate unit.
	otc_mac u_mac (
		.clk   (clk),
		.ctl   (mac_ctl),
		.feat  (feat_rdata),
		.coef  (coef_q),
		.cut   (cut_q),
		.below (below)
	);

	// Next-state logic of the walk sequencer.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (op_t'(item_ch.operation) == OP_EVAL)) begin
					state_nxt = ST_RD_NODE;
				end
			end
			ST_RD_NODE: state_nxt = ST_CHK;
			ST_CHK: begin
				if (nd_child == 8'd0 || step_over) begin
					state_nxt = ST_FIN;
				end else begin
					state_nxt = ST_CNT_RD;
				end
			end
			ST_CNT_RD: state_nxt = ST_CNT_AC;
			ST_CNT_AC: state_nxt = cnt_last ? ST_SEG : ST_CNT_RD;
			ST_SEG:    state_nxt = seg_neg ? ST_FIN : ST_PR_RD;
			ST_PR_RD:  state_nxt = rows_done ? ST_FIN : ST_PR_EV;
			ST_PR_EV: begin
				if (rw_feat == '0) begin
					state_nxt = seg_match ? ST_CMP : ST_PR_RD;
				end else if (row_hit) begin
					state_nxt = (feat_bad || rw_feat == FEAT_W'(0)) ? ST_FIN : ST_FT_EV;
				end else begin
					state_nxt = ST_PR_RD;
				end
			end
			ST_FT_EV: state_nxt = ST_ACC;
			ST_ACC:   state_nxt = ST_PR_RD;
			ST_CMP:   state_nxt = next_bad ? ST_FIN : ST_RD_NODE;
			ST_FIN:   state_nxt = out_free ? ST_IDLE : ST_FIN;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// Output logic: handshake, store writes, read addresses and unit control.
	always_comb begin
		item_ch.ready = state_q == ST_IDLE;
		node_we = accept && (op_t'(item_ch.operation) == OP_LOAD_NODE)
			&& (32'(item_ch.index) < MAX_NODES);
		row_we  = accept && (op_t'(item_ch.operation) == OP_LOAD_ROW)
			&& (32'(item_ch.index) < MAX_PROJ_ROWS);
		feat_we = accept && (op_t'(item_ch.operation) == OP_LOAD_FEAT)
			&& (32'(item_ch.index) < NUM_FEATURES);
		node_raddr = (state_q == ST_CNT_RD) ? k_q : cur_q;
		feat_raddr = FAW'(rw_feat - FEAT_W'(1));
		mac_ctl     = '0;
		mac_ctl.clr = state_q == ST_CHK;
		mac_ctl.mul = state_q == ST_FT_EV;
		mac_ctl.acc = state_q == ST_ACC;
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Loaded row count, the highest row written plus one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q <= '0;
		end else if (row_we && (32'(item_ch.index) + 1 > 32'(row_cnt_q))) begin
			row_cnt_q <= RCW'(32'(item_ch.index) + 1);
		end
	end

	// Output register: filled when the walk ends, emptied when the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			out_label_q <= res_err_q ? '0 : res_label_q;
			out_err_q   <= res_err_q;
		end
	end

	// Walk datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cur_q     <= '0;
				steps_q   <= '0;
				res_err_q <= 1'b0;
			end
			ST_CHK: begin
				child_q     <= nd_child;
				grp_q       <= nd_group;
				cut_q       <= nd_cut;
				res_label_q <= nd_label;
				k_q         <= '0;
				leaves_q    <= '0;
				if (nd_child != 8'd0 && step_over) begin
					res_err_q <= 1'b1;
				end
				steps_q <= steps_q + SW'(1);
			end
			ST_CNT_AC: begin
				leaves_q <= leaves_q + (NAW + 1)'(nd_group == 8'd0);
				k_q      <= k_q + NAW'(1);
			end
			ST_SEG: begin
				seg_q    <= seg_full[NAW:0];
				t_q      <= '0;
				delims_q <= '0;
				if (seg_neg) begin
					res_err_q <= 1'b1;
				end
			end
			ST_PR_RD: begin
				if (rows_done) begin
					res_err_q <= 1'b1;
				end
			end
			ST_PR_EV: begin
				coef_q <= rw_coef;
				if (rw_feat == '0) begin
					delims_q <= delims_q + RCW'(1);
					t_q      <= t_q + RCW'(1);
				end else if (row_hit) begin
					if (feat_bad) begin
						res_err_q <= 1'b1;
					end
				end else begin
					t_q <= t_q + RCW'(1);
				end
			end
			ST_ACC: t_q <= t_q + RCW'(1);
			ST_CMP: begin
				cur_q <= NAW'(next_node);
				if (next_bad) begin
					res_err_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign result_ch.valid       = out_valid_q;
	assign result_ch.class_label = out_label_q;
	assign result_ch.walk_error  = out_err_q;

	// Checks on the sequencer and the result register.
	`OTC_ASSERT_NOW(a_ready_idle, item_ch.ready, state_q == ST_IDLE, "ready outside idle")
	`OTC_ASSERT_NOW(a_rose_fin, $rose(out_valid_q), $past(state_q) == ST_FIN, "result not from walk end")
	`OTC_ASSERT_NOW(a_err_label, out_valid_q && out_err_q, out_label_q == '0, "error with nonzero label")
	`OTC_ASSERT_NEXT(a_fin_idle, (state_q == ST_FIN) && out_free, out_valid_q && (state_q == ST_IDLE), "result not posted")
endmodule
